// ----- src/llgt_pkg.sv -----
package llgt_pkg;

    // field widths
    localparam int unsigned COMP_W  = 32;
    localparam int unsigned RHS_W   = 48;
    localparam int unsigned GYRO_W  = 34;
    localparam int unsigned DAMP_W  = 16;

    // square root unit: 96-bit radicand, 48-bit root
    localparam int unsigned SQ_W       = 96;
    localparam int unsigned ROOT_W     = SQ_W / 2;
    localparam int unsigned ROOT_CNT_W = $clog2(ROOT_W);
    localparam int unsigned REM_W      = ROOT_W + 1;

    // configuration register indexes
    localparam logic REG_GYRO    = 1'b0;
    localparam logic REG_DAMPING = 1'b1;

    localparam logic signed [COMP_W-1:0] COMP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COMP_W-1:0] COMP_MIN = 32'sh8000_0000;

endpackage

// ----- src/llgt_isqrt.sv -----
module llgt_isqrt
    import llgt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic                  active_reg;
    logic                  done_reg;
    logic [ROOT_CNT_W-1:0] cnt_reg;
    logic [SQ_W-1:0]       rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;

    logic [REM_W+1:0]      rem_sh;
    logic [REM_W+1:0]      trial;
    logic [REM_W+1:0]      diff;
    logic                  take;

    // restoring digit recurrence, one root bit per cycle
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        take   = (rem_sh >= trial);
        diff   = rem_sh - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= !start && active_reg && (cnt_reg == ROOT_CNT_W'(ROOT_W - 1));
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                if (cnt_reg == ROOT_CNT_W'(ROOT_W - 1))
                    active_reg <= 1'b0;
                cnt_reg <= cnt_reg + ROOT_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (active_reg)
        begin
            rad_reg <= {rad_reg[SQ_W-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= diff[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- src/llg_torque_rhs.sv -----
// llg_torque_rhs: landau-lifshitz-gilbert right-hand side, one mesh node per transaction
//
// input stream s_*: tdata carries m_x, m_y, m_z, h_x, h_y, h_z (32 bits each, lowest first),
// tlast marks the final node of a batch. output stream m_*: tdata carries rhs_x, rhs_y,
// rhs_z and max_norm (48 bits each), tlast echoes the input tlast; max_norm is the running
// maximum of |dm/dt| and clears after the node marked last.
// configuration: cfg_we with cfg_addr 0 writes the damped gyro ratio, 1 writes the damping.
// write only while no node is in flight.
//
// timing: one signed 36x36 multiplier with a 98-bit accumulator runs 30 multiply steps, each
// a multiply state then an accumulate state, then a radix-2 square root unit forms the root;
// m_tvalid and s_tready rise in the same cycle once the output register is free.
// one node is in flight at a time; a new node is taken only after the last result is loaded.
// the output register holds a finished result while the next node is computed; if the
// receiver still holds the previous result when the next one finishes, the block waits.
// reset clears the sequencer, the configuration registers, the running maximum and the output valid.
module llg_torque_rhs
    import llgt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [191:0]  s_tdata,   // m_x, m_y, m_z, h_x, h_y, h_z
    input  logic          s_tlast,   // last_node
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [191:0]  m_tdata,   // rhs_x, rhs_y, rhs_z, max_norm
    output logic          m_tlast,   // batch_end
    input  logic          cfg_we,
    input  logic          cfg_addr,
    input  logic [33:0]   cfg_wdata
);

    localparam int unsigned ACC_W  = 98;
    localparam int unsigned OP_W   = 36;
    localparam int unsigned PROD_W = 2 * OP_W;
    localparam int unsigned D_W    = 36;
    localparam int unsigned AT_W   = 52;
    localparam int unsigned HALF_W = AT_W / 2;
    localparam int unsigned Q_W    = ACC_W - 40;
    localparam logic [4:0]  LAST_STEP = 5'd29;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< 39;
    localparam logic [Q_W-1:0] POS_LIM = Q_W'(48'h7FFF_FFFF_FFFF);
    localparam logic [Q_W-1:0] NEG_LIM = Q_W'(48'h8000_0000_0000);

    typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_ACC, ST_ROOT, ST_DONE} state_t;
    typedef enum logic [1:0] {BASE_ZERO, BASE_ACC, BASE_ROUND, BASE_PSHIFT} base_sel_t;
    typedef enum logic [1:0] {SH_0, SH_25, SH_26, SH_48} shift_sel_t;
    typedef enum logic [2:0] {WR_NONE, WR_P, WR_D, WR_T, WR_MG, WR_SQ} wr_sel_t;

    state_t state_reg;
    logic [4:0] step_reg;

    logic [GYRO_W-1:0] gyro_reg;
    logic [DAMP_W-1:0] damp_reg;
    logic [RHS_W-1:0]  run_max_reg;

    logic signed [COMP_W-1:0] m_reg [3];
    logic signed [COMP_W-1:0] h_reg [3];
    logic signed [COMP_W-1:0] p_reg [3];
    logic signed [D_W-1:0]    d_reg [3];
    logic [AT_W-1:0]          at_reg [3];
    logic                     neg_reg [3];
    logic [RHS_W-1:0]         mg_reg [3];
    logic [RHS_W-1:0]         rhs_reg [3];
    logic                     last_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic          out_valid_reg;
    logic [191:0]  out_data_reg;
    logic          out_last_reg;

    // step decode
    logic signed [OP_W-1:0] op_a;
    logic signed [OP_W-1:0] op_b;
    base_sel_t  base_sel;
    shift_sel_t shift_sel;
    wr_sel_t    wr_sel;
    logic       sub;
    logic [1:0] k;
    logic [1:0] ia;
    logic [1:0] ib;
    logic [1:0] xi;
    logic [4:0] loc;
    logic signed [COMP_W-1:0] x_op;

    // accumulator path
    logic signed [ACC_W-1:0] base_val;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] t_abs;
    logic signed [COMP_W-1:0] p_val;
    logic [Q_W-1:0]   q_val;
    logic [Q_W-1:0]   q_lim;
    logic [RHS_W-1:0] mg_val;
    logic [RHS_W-1:0] rhs_val;

    logic              sq_start;
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic [RHS_W-1:0]  new_max;
    logic              out_free;

    always_comb
    begin
        op_a      = '0;
        op_b      = '0;
        base_sel  = BASE_ZERO;
        shift_sel = SH_0;
        wr_sel    = WR_NONE;
        sub       = 1'b0;
        k         = 2'd0;
        ia        = 2'd1;
        ib        = 2'd2;
        xi        = 2'd0;
        loc       = '0;
        x_op      = '0;
        if (step_reg < 5'd12)
        begin
            // cross products: m x h, then m x p
            loc = (step_reg < 5'd6) ? step_reg : step_reg - 5'd6;
            k   = loc[2:1];
            unique case (loc[2:1])
                2'd0:
                begin
                    ia = 2'd1;
                    ib = 2'd2;
                end
                2'd1:
                begin
                    ia = 2'd2;
                    ib = 2'd0;
                end
                default:
                begin
                    ia = 2'd0;
                    ib = 2'd1;
                end
            endcase
            xi   = loc[0] ? ia : ib;
            x_op = (step_reg < 5'd6) ? h_reg[xi] : p_reg[xi];
            op_a = OP_W'(loc[0] ? m_reg[ib] : m_reg[ia]);
            op_b = OP_W'(x_op);
            sub      = loc[0];
            base_sel = loc[0] ? BASE_ACC : BASE_ZERO;
            if (loc[0])
                wr_sel = (step_reg < 5'd6) ? WR_P : WR_D;
        end
        else if (step_reg < 5'd15)
        begin
            // t = p * 2^16 + damping * d
            loc      = step_reg - 5'd12;
            k        = loc[1:0];
            op_a     = OP_W'({1'b0, damp_reg});
            op_b     = d_reg[k];
            base_sel = BASE_PSHIFT;
            wr_sel   = WR_T;
        end
        else if (step_reg < 5'd21)
        begin
            // gyro * |t| in two limbs, rounding bias preloaded
            loc = step_reg - 5'd15;
            k   = loc[2:1];
            op_a = OP_W'({1'b0, gyro_reg});
            if (loc[0])
            begin
                op_b      = OP_W'({1'b0, at_reg[k][AT_W-1:HALF_W]});
                base_sel  = BASE_ACC;
                shift_sel = SH_26;
                wr_sel    = WR_MG;
            end
            else
            begin
                op_b      = OP_W'({1'b0, at_reg[k][HALF_W-1:0]});
                base_sel  = BASE_ROUND;
            end
        end
        else
        begin
            // sum of squares, each magnitude split in 24-bit halves
            loc = step_reg - 5'd21;
            unique case (loc) inside
                [5'd0:5'd2]: k = 2'd0;
                [5'd3:5'd5]: k = 2'd1;
                default:     k = 2'd2;
            endcase
            base_sel = (loc == 5'd0) ? BASE_ZERO : BASE_ACC;
            unique case (loc) inside
                5'd0, 5'd3, 5'd6:
                begin
                    op_a      = OP_W'({1'b0, mg_reg[k][23:0]});
                    op_b      = OP_W'({1'b0, mg_reg[k][23:0]});
                    shift_sel = SH_0;
                end
                5'd1, 5'd4, 5'd7:
                begin
                    op_a      = OP_W'({1'b0, mg_reg[k][47:24]});
                    op_b      = OP_W'({1'b0, mg_reg[k][23:0]});
                    shift_sel = SH_25;
                end
                default:
                begin
                    op_a      = OP_W'({1'b0, mg_reg[k][47:24]});
                    op_b      = OP_W'({1'b0, mg_reg[k][47:24]});
                    shift_sel = SH_48;
                end
            endcase
            if (step_reg == LAST_STEP)
                wr_sel = WR_SQ;
        end
    end

    always_comb
    begin
        case (base_sel)
            BASE_ZERO:   base_val = '0;
            BASE_ACC:    base_val = acc_reg;
            BASE_ROUND:  base_val = ROUND_BIAS;
            BASE_PSHIFT: base_val = ACC_W'(p_reg[k]) <<< 16;
            default:     base_val = '0;
        endcase
        prod_ext = ACC_W'(prod_reg);
        case (shift_sel)
            SH_0:    addend = prod_ext;
            SH_25:   addend = prod_ext <<< 25;
            SH_26:   addend = prod_ext <<< 26;
            SH_48:   addend = prod_ext <<< 48;
            default: addend = prod_ext;
        endcase
        sum = sub ? base_val - addend : base_val + addend;

        if (sum[ACC_W-1:60] == {(ACC_W-60){sum[60]}})
            p_val = sum[60:29];
        else
            p_val = sum[ACC_W-1] ? COMP_MIN : COMP_MAX;

        t_abs = sum[ACC_W-1] ? -sum : sum;

        q_val   = sum[ACC_W-1:40];
        q_lim   = neg_reg[k] ? NEG_LIM : POS_LIM;
        mg_val  = (q_val > q_lim) ? q_lim[RHS_W-1:0] : q_val[RHS_W-1:0];
        rhs_val = neg_reg[k] ? (~mg_val) + RHS_W'(1) : mg_val;
    end

    assign sq_start = (state_reg == ST_ACC) && (wr_sel == WR_SQ);

    llgt_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sum[SQ_W-1:0]),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign new_max  = (sq_root > run_max_reg) ? sq_root : run_max_reg;
    assign out_free = !out_valid_reg || m_tready;

    // sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            gyro_reg      <= '0;
            damp_reg      <= '0;
            run_max_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_GYRO:    gyro_reg <= cfg_wdata;
                    REG_DAMPING: damp_reg <= cfg_wdata[DAMP_W-1:0];
                    default:     ;
                endcase
            end

            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (step_reg == LAST_STEP)
                        state_reg <= ST_ROOT;
                    else
                    begin
                        step_reg  <= step_reg + 5'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_ROOT:
                begin
                    if (sq_done)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        run_max_reg   <= last_reg ? '0 : new_max;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            m_reg[0] <= s_tdata[31:0];
            m_reg[1] <= s_tdata[63:32];
            m_reg[2] <= s_tdata[95:64];
            h_reg[0] <= s_tdata[127:96];
            h_reg[1] <= s_tdata[159:128];
            h_reg[2] <= s_tdata[191:160];
            last_reg <= s_tlast;
        end

        if (state_reg == ST_MUL)
            prod_reg <= op_a * op_b;

        if (state_reg == ST_ACC)
        begin
            acc_reg <= sum;
            case (wr_sel)
                WR_P:
                    p_reg[k] <= p_val;
                WR_D:
                    d_reg[k] <= sum[D_W+28:29];
                WR_T:
                begin
                    neg_reg[k] <= !sum[ACC_W-1] && (sum != '0);
                    at_reg[k]  <= t_abs[AT_W-1:0];
                end
                WR_MG:
                begin
                    mg_reg[k]  <= mg_val;
                    rhs_reg[k] <= rhs_val;
                end
                default: ;
            endcase
        end

        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg <= {new_max, rhs_reg[2], rhs_reg[1], rhs_reg[0]};
            out_last_reg <= last_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- bench/testbench.sv -----
module testbench
    import llgt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {ROW_NODE, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        logic [47:0] rhs_x;
        logic [47:0] rhs_y;
        logic [47:0] rhs_z;
        logic [47:0] max_norm;
        logic        batch_end;
    } torque_result_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [GYRO_W-1:0]     gyro;
        logic [DAMP_W-1:0]     alpha;
        logic [COMP_W-1:0]     mx;
        logic [COMP_W-1:0]     my;
        logic [COMP_W-1:0]     mz;
        logic [COMP_W-1:0]     hx;
        logic [COMP_W-1:0]     hy;
        logic [COMP_W-1:0]     hz;
        logic                  last;
        logic                  typed;
        torque_result_t        res;
    } stim_row_t;

    localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] C_MIN = 32'h8000_0000;
    localparam logic [31:0] ONE   = 32'h2000_0000;   // 1.0 in Q2.29
    localparam logic [31:0] M1    = 32'hFFFF_FFFF;   // -1 lsb
    localparam logic [31:0] DIAG  = 32'h16A0_9E66;   // 1/sqrt(2)

    localparam longint P_HI = 64'sd2147483647;
    localparam longint P_LO = -64'sd2147483648;
    localparam logic [127:0] POS_MAG_MAX = (128'd1 << 47) - 128'd1;
    localparam logic [127:0] NEG_MAG_MAX = 128'd1 << 47;

    localparam torque_result_t RES_ZERO     = '0;
    localparam torque_result_t RES_ZERO_END = '{48'd0, 48'd0, 48'd0, 48'd0, 1'b1};
    // half an lsb rounds away from zero
    localparam torque_result_t RES_HALF_NEG = '{48'd0, 48'd0, 48'hFFFF_FFFF_FFFF, 48'd1, 1'b1};
    localparam torque_result_t RES_HALF_POS = '{48'd0, 48'd0, 48'd1, 48'd1, 1'b1};

    localparam int N_DIRECTED = 20;
    localparam int RAND_PHASES = 5;
    localparam int RAND_PER_PHASE = 260;

    localparam stim_row_t directed [N_DIRECTED] = '{
        // straight after reset the ratio is zero, so every torque is zero
        '{ROW_NODE, '0, '0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, RES_ZERO},
        '{ROW_NODE, '0, '0, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b0, 1'b1, RES_ZERO},
        '{ROW_NODE, '0, '0, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0, 1'b1, RES_ZERO},
        '{ROW_NODE, '0, '0, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 1'b0, 1'b1, RES_ZERO},
        '{ROW_NODE, '0, '0, ONE, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 1'b1, 1'b1, RES_ZERO_END},
        '{ROW_CONFIG, 34'h0_0080_0000, 16'd0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0, RES_ZERO},
        '{ROW_NODE, '0, '0, ONE, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 1'b1, 1'b1, RES_HALF_NEG},
        '{ROW_NODE, '0, '0, ONE, 32'd0, 32'd0, 32'd0, M1, 32'd0, 1'b1, 1'b1, RES_HALF_POS},
        '{ROW_NODE, '0, '0, 32'd1, 32'd0, 32'd0, 32'd0, M1, 32'd0, 1'b0, 1'b0, RES_ZERO},
        '{ROW_NODE, '0, '0, ONE, ONE, 32'd0, 32'd0, 32'd0, 32'h0100_0000,
          1'b1, 1'b0, RES_ZERO},
        '{ROW_CONFIG, '1, '1, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0, RES_ZERO},
        // precession term clips at both 32-bit limits here
        '{ROW_NODE, '0, '0, C_MAX, 32'd0, 32'd0, 32'd0, C_MAX, 32'd0, 1'b0, 1'b0, RES_ZERO},
        '{ROW_NODE, '0, '0, C_MIN, 32'd0, 32'd0, 32'd0, C_MAX, 32'd0, 1'b0, 1'b0, RES_ZERO},
        '{ROW_NODE, '0, '0, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, 1'b0, 1'b0, RES_ZERO},
        '{ROW_NODE, '0, '0, ONE, 32'd0, 32'd0, 32'd0, 32'h0100_0000, 32'h0100_0000,
          1'b1, 1'b0, RES_ZERO},
        '{ROW_NODE, '0, '0, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, 32'd0, 1'b1, 1'b0, RES_ZERO},
        '{ROW_CONFIG, 34'd14_500_000_000, 16'd6554, '0, '0, '0, '0, '0, '0,
          1'b0, 1'b0, RES_ZERO},
        '{ROW_NODE, '0, '0, ONE, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 1'b0, 1'b0, RES_ZERO},
        '{ROW_NODE, '0, '0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b0, 1'b0, RES_ZERO},
        '{ROW_NODE, '0, '0, DIAG, 32'd0, DIAG, 32'd0, 32'd0, 32'h0010_0000, 1'b1, 1'b0, RES_ZERO}
    };

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;    // m_x, m_y, m_z, h_x, h_y, h_z
    logic         s_tlast;    // last_node
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;    // rhs_x, rhs_y, rhs_z, max_norm
    logic         m_tlast;    // batch_end
    logic         cfg_we;
    logic         cfg_addr;
    logic [33:0]  cfg_wdata;

    logic [GYRO_W-1:0] gyro_bar = '0;
    logic [DAMP_W-1:0] alpha = '0;
    logic [47:0]       batch_peak = '0;
    bit                steady = 1'b0;

    torque_result_t pending_results [$];
    int unsigned    fault_count = 0;
    int unsigned    result_count = 0;

    llg_torque_rhs dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // llg torque for one node, updates the running batch maximum
    function automatic torque_result_t predict_torque(input logic [191:0] node, input bit last);
        longint         m [3];
        longint         h [3];
        longint         p [3];
        longint         d [3];
        longint         t;
        longint         damp;
        logic [63:0]    at;
        logic [127:0]   prod;
        logic [127:0]   mg;
        logic [127:0]   sumsq;
        logic [127:0]   root;
        logic [127:0]   cand;
        logic [47:0]    comp [3];
        logic [47:0]    norm;
        torque_result_t r;
        int             k;
        int             i1;
        int             i2;
        int             b;

        for (k = 0; k < 3; k++)
        begin
            m[k] = longint'($signed(node[32*k +: 32]));
            h[k] = longint'($signed(node[96 + 32*k +: 32]));
        end
        for (k = 0; k < 3; k++)
        begin
            i1 = (k + 1) % 3;
            i2 = (k + 2) % 3;
            p[k] = (m[i1] * h[i2] - m[i2] * h[i1]) >>> 29;
            if (p[k] > P_HI)
                p[k] = P_HI;
            else if (p[k] < P_LO)
                p[k] = P_LO;
        end
        for (k = 0; k < 3; k++)
        begin
            i1 = (k + 1) % 3;
            i2 = (k + 2) % 3;
            d[k] = (m[i1] * p[i2] - m[i2] * p[i1]) >>> 29;
        end

        damp = longint'(alpha);
        sumsq = '0;
        for (k = 0; k < 3; k++)
        begin
            t = p[k] * 65536 + damp * d[k];
            at = (t < 0) ? -t : t;
            prod = {64'd0, at} * {94'd0, gyro_bar};
            mg = (prod + (128'd1 << 39)) >> 40;
            // sign flips: positive torque gives a negative rate
            if (t > 0)
            begin
                if (mg > NEG_MAG_MAX)
                    mg = NEG_MAG_MAX;
                comp[k] = -mg[47:0];
            end
            else
            begin
                if (mg > POS_MAG_MAX)
                    mg = POS_MAG_MAX;
                comp[k] = mg[47:0];
            end
            sumsq = sumsq + mg * mg;
        end

        root = '0;
        for (b = 47; b >= 0; b--)
        begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sumsq)
                root = cand;
        end
        norm = root[47:0];
        if (norm > batch_peak)
            batch_peak = norm;

        r.rhs_x = comp[0];
        r.rhs_y = comp[1];
        r.rhs_z = comp[2];
        r.max_norm = batch_peak;
        r.batch_end = last;
        if (last)
            batch_peak = '0;
        return r;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 30);
        return $urandom_range(40, 200);
    endfunction

    // mostly unit-scale magnetisation with fields of random magnitude, the rest raw bits
    function automatic logic [191:0] random_node();
        logic [191:0] n;
        int           k;
        if ($urandom_range(0, 99) < 30)
        begin
            for (k = 0; k < 6; k++)
                n[32*k +: 32] = $urandom;
        end
        else
        begin
            for (k = 0; k < 3; k++)
            begin
                n[32*k +: 32] = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
                n[96 + 32*k +: 32] = $signed($urandom) >>> $urandom_range(0, 31);
            end
        end
        return n;
    endfunction

    task automatic send_node(input logic [191:0] node, input bit last, input bit typed,
                             input torque_result_t typed_res);
        torque_result_t want;
        int unsigned    gap;
        s_tvalid <= 1'b1;
        s_tdata <= node;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        want = predict_torque(node, last);
        if (typed)
            want = typed_res;
        pending_results.push_back(want);
        gap = idle_len();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [GYRO_W-1:0] g, input logic [DAMP_W-1:0] a);
        cfg_we <= 1'b1;
        cfg_addr <= REG_GYRO;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_addr <= REG_DAMPING;
        cfg_wdata <= {18'd0, a};
        @(posedge clk);
        cfg_we <= 1'b0;
        gyro_bar = g;
        alpha = a;
    endtask

    task automatic check_field(input string what, input logic [47:0] want, input logic [47:0] got);
        if (want !== got)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("result %0d %s: expected %h, got %h", result_count, what, want, got);
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin : ready_loop
            int unsigned n;
            n = idle_len();
            if (n != 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : collect
        torque_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("result %0d arrived with nothing outstanding", result_count);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("rhs_x", want.rhs_x, m_tdata[47:0]);
                check_field("rhs_y", want.rhs_y, m_tdata[95:48]);
                check_field("rhs_z", want.rhs_z, m_tdata[143:96]);
                check_field("max_norm", want.max_norm, m_tdata[191:144]);
                check_field("batch_end", {47'd0, want.batch_end}, {47'd0, m_tlast});
            end
            result_count++;
        end
    end

    initial
    begin
        #35ms;
        $display("testbench failed");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t         row;
        logic [GYRO_W-1:0] g;
        logic [DAMP_W-1:0] a;
        int                i;
        int                ph;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_GYRO;
        cfg_wdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
        begin
            row = directed[i];
            if (row.kind == ROW_CONFIG)
            begin
                drain();
                set_config(row.gyro, row.alpha);
            end
            else
                send_node({row.hz, row.hy, row.hx, row.mz, row.my, row.mx}, row.last,
                          row.typed, row.res);
        end

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    g = 34'd14_500_000_000;
                    a = 16'd6554;
                end
                1:
                begin
                    g = '1;
                    a = '1;
                end
                2:
                begin
                    g = {2'($urandom_range(0, 3)), $urandom};
                    a = 16'($urandom);
                end
                3:
                begin
                    g = {2'($urandom_range(0, 3)), $urandom};
                    a = '0;
                end
                default:
                begin
                    g = 34'($urandom_range(1, 1 << 20));
                    a = '1;
                end
            endcase
            set_config(g, a);
            steady = (ph == 2);
            for (i = 0; i < RAND_PER_PHASE; i++)
                send_node(random_node(), $urandom_range(0, 9) == 0, 1'b0, RES_ZERO);
        end

        drain();
        repeat (120) @(posedge clk);
        if (pending_results.size() != 0)
            $display("%0d results never arrived", pending_results.size());
        if (fault_count == 0 && pending_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
